// File: hdl/cobs_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package cobs_pkg;

    localparam int ADDR_W = 9;
    localparam int DATA_W = 8;
    localparam int NUM_WR = 4;
    localparam int CNT_W  = 3;
    localparam int PTR_W  = 2;

    localparam logic [DATA_W-1:0] CODE_FULL  = 8'hFF;
    localparam logic [DATA_W-1:0] CODE_START = 8'h01;
    localparam logic [DATA_W-1:0] DELIM      = 8'h00;

    localparam logic [ADDR_W-1:0] CODE_SLOT_INIT = 9'd0;
    localparam logic [ADDR_W-1:0] NEXT_SLOT_INIT = 9'd1;

    typedef struct packed {
        logic [ADDR_W-1:0] addr;
        logic [DATA_W-1:0] data;
    } wr_t;

endpackage

`default_nettype wire

// File: hdl/cobs_frame_encoder.sv
`timescale 1ns / 1ps
`default_nettype none

// channel  | handshake           | payload
// ---------+---------------------+--------------------------------------------
// input    | in_valid, in_ready  | raw_byte, end_of_raw
// output   | out_valid, out_ready| write_addr, write_data, frame_done, too_long
//
// one request enters per cycle when it yields at most one write; each extra
// write (code byte, final code, delimiter) takes one more queue entry, up to 4 total
// writes of one request are loaded at once into a 4-entry write queue and drained
// one per cycle; a new request is taken when the queue empties in that cycle
// rst_n clears the encoder state and the write queue asynchronously
// out_ready low holds the queue head and stalls input once the queue is busy

module cobs_frame_encoder #(
    parameter int MAX_RAW_BYTES = 256
) (
    input  wire                          clk,
    input  wire                          rst_n,
    input  wire                          in_valid,
    output logic                         in_ready,
    input  wire  [cobs_pkg::DATA_W-1:0]  raw_byte,
    input  wire                          end_of_raw,
    output logic                         out_valid,
    input  wire                          out_ready,
    output logic [cobs_pkg::ADDR_W-1:0]  write_addr,
    output logic [cobs_pkg::DATA_W-1:0]  write_data,
    output logic                         frame_done,
    output logic                         too_long
);

    localparam int SEEN_W = $clog2(MAX_RAW_BYTES + 1);
    localparam logic [SEEN_W-1:0] SEEN_MAX = SEEN_W'(MAX_RAW_BYTES);

    logic [cobs_pkg::DATA_W-1:0] run_code_reg,  run_code_next;
    logic [cobs_pkg::ADDR_W-1:0] code_slot_reg, code_slot_next;
    logic [cobs_pkg::ADDR_W-1:0] next_slot_reg, next_slot_next;
    logic [SEEN_W-1:0]           raw_seen_reg,  raw_seen_next;
    logic                        overflowed_reg, overflowed_next;

    cobs_pkg::wr_t pend_reg [cobs_pkg::NUM_WR];
    cobs_pkg::wr_t pend_next [cobs_pkg::NUM_WR];
    logic [cobs_pkg::CNT_W-1:0] cnt_reg,  cnt_next;
    logic [cobs_pkg::PTR_W-1:0] head_reg, head_next;
    logic                       last_reg, last_next;
    logic                       ovf_reg,  ovf_next;

    cobs_pkg::wr_t              wr [cobs_pkg::NUM_WR];
    logic [cobs_pkg::CNT_W-1:0] n;
    logic                       drop;
    logic                       ovf;
    logic [cobs_pkg::DATA_W-1:0] rc;
    logic [cobs_pkg::DATA_W-1:0] rc_inc;
    logic [cobs_pkg::ADDR_W-1:0] cs;
    logic [cobs_pkg::ADDR_W-1:0] ns;
    logic                       in_fire;
    logic                       out_fire;

    assign out_valid = (cnt_reg != '0);
    assign out_fire  = out_valid && out_ready;
    assign in_ready  = (cnt_reg == '0) ||
                       ((cnt_reg == cobs_pkg::CNT_W'(1)) && out_ready);
    assign in_fire   = in_valid && in_ready;

    assign write_addr = pend_reg[head_reg].addr;
    assign write_data = pend_reg[head_reg].data;
    assign frame_done = last_reg && (cnt_reg == cobs_pkg::CNT_W'(1));
    assign too_long   = ovf_reg;

    // build the writes of one request
    always_comb
    begin
        n      = '0;
        drop   = (raw_seen_reg == SEEN_MAX);
        ovf    = overflowed_reg || drop;
        rc     = run_code_reg;
        cs     = code_slot_reg;
        ns     = next_slot_reg;
        rc_inc = run_code_reg + 8'd1;
        for (int i = 0; i < cobs_pkg::NUM_WR; i++)
        begin
            wr[i] = '0;
        end
        if (!drop)
        begin
            if (raw_byte == cobs_pkg::DELIM)
            begin
                wr[n[cobs_pkg::PTR_W-1:0]] = '{addr: cs, data: rc};
                n  = n + 3'd1;
                cs = next_slot_reg;
                ns = next_slot_reg + 9'd1;
                rc = cobs_pkg::CODE_START;
            end
            else
            begin
                wr[n[cobs_pkg::PTR_W-1:0]] = '{addr: ns, data: raw_byte};
                n  = n + 3'd1;
                ns = next_slot_reg + 9'd1;
                rc = rc_inc;
                if (rc_inc == cobs_pkg::CODE_FULL)
                begin
                    // full run closes the block
                    wr[n[cobs_pkg::PTR_W-1:0]] = '{addr: cs, data: cobs_pkg::CODE_FULL};
                    n  = n + 3'd1;
                    cs = next_slot_reg + 9'd1;
                    ns = next_slot_reg + 9'd2;
                    rc = cobs_pkg::CODE_START;
                end
            end
        end
        if (end_of_raw)
        begin
            wr[n[cobs_pkg::PTR_W-1:0]] = '{addr: cs, data: rc};
            n  = n + 3'd1;
            wr[n[cobs_pkg::PTR_W-1:0]] = '{addr: ns, data: cobs_pkg::DELIM};
            n  = n + 3'd1;
        end
    end

    always_comb
    begin
        run_code_next   = run_code_reg;
        code_slot_next  = code_slot_reg;
        next_slot_next  = next_slot_reg;
        raw_seen_next   = raw_seen_reg;
        overflowed_next = overflowed_reg;
        cnt_next        = cnt_reg;
        head_next       = head_reg;
        last_next       = last_reg;
        ovf_next        = ovf_reg;
        for (int i = 0; i < cobs_pkg::NUM_WR; i++)
        begin
            pend_next[i] = pend_reg[i];
        end
        if (out_fire)
        begin
            cnt_next  = cnt_reg - 3'd1;
            head_next = head_reg + 2'd1;
        end
        if (in_fire)
        begin
            for (int i = 0; i < cobs_pkg::NUM_WR; i++)
            begin
                pend_next[i] = wr[i];
            end
            cnt_next  = n;
            head_next = '0;
            last_next = end_of_raw;
            ovf_next  = ovf;
            if (end_of_raw)
            begin
                run_code_next   = cobs_pkg::CODE_START;
                code_slot_next  = cobs_pkg::CODE_SLOT_INIT;
                next_slot_next  = cobs_pkg::NEXT_SLOT_INIT;
                raw_seen_next   = '0;
                overflowed_next = 1'b0;
            end
            else
            begin
                run_code_next   = rc;
                code_slot_next  = cs;
                next_slot_next  = ns;
                raw_seen_next   = drop ? raw_seen_reg : raw_seen_reg + SEEN_W'(1);
                overflowed_next = ovf;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_code_reg   <= cobs_pkg::CODE_START;
            code_slot_reg  <= cobs_pkg::CODE_SLOT_INIT;
            next_slot_reg  <= cobs_pkg::NEXT_SLOT_INIT;
            raw_seen_reg   <= '0;
            overflowed_reg <= 1'b0;
            cnt_reg        <= '0;
            head_reg       <= '0;
            last_reg       <= 1'b0;
            ovf_reg        <= 1'b0;
        end
        else
        begin
            run_code_reg   <= run_code_next;
            code_slot_reg  <= code_slot_next;
            next_slot_reg  <= next_slot_next;
            raw_seen_reg   <= raw_seen_next;
            overflowed_reg <= overflowed_next;
            cnt_reg        <= cnt_next;
            head_reg       <= head_next;
            last_reg       <= last_next;
            ovf_reg        <= ovf_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < cobs_pkg::NUM_WR; i++)
        begin
            pend_reg[i] <= pend_next[i];
        end
    end

    // queue never holds more than one request worth of writes
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg <= cobs_pkg::CNT_W'(cobs_pkg::NUM_WR)) &&
        ({1'b0, head_reg} + cnt_reg <= cobs_pkg::CNT_W'(cobs_pkg::NUM_WR)))
        else $error("write queue overrun");

    // a request is taken only when the queue drains this cycle
    a_accept_drain: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |-> (cnt_reg == '0) || (cnt_reg == cobs_pkg::CNT_W'(1) && out_fire))
        else $error("request taken over pending writes");

    // frame end restores the initial encoder state
    a_frame_reset: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire && end_of_raw |=> (code_slot_reg == cobs_pkg::CODE_SLOT_INIT) &&
        (next_slot_reg == cobs_pkg::NEXT_SLOT_INIT) && (raw_seen_reg == '0) &&
        !overflowed_reg)
        else $error("encoder state not reset after frame");

    // delimiter write carries zero data
    a_delim_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && frame_done |-> (write_data == cobs_pkg::DELIM))
        else $error("frame end write is not a delimiter");

    // raw byte count saturates at the limit
    a_seen_limit: assert property (@(posedge clk) disable iff (!rst_n)
        raw_seen_reg <= SEEN_MAX)
        else $error("raw byte count past limit");

endmodule

`default_nettype wire
